>>> design/fsc_pkg.sv
// fsc_pkg: types, membership breakpoints, rule base and sequencer states
// for the fuzzy speed controller. No dependencies.
package fsc_pkg;

  typedef logic signed [17:0] coord_t;
  typedef logic [16:0]        grade_t;

  typedef struct packed {
    coord_t a;
    coord_t b;
    coord_t c;
    coord_t d;
  } trap_t;

  typedef struct packed {
    logic [2:0] ang;
    logic [1:0] dst;
    logic [1:0] lin;
    logic [2:0] turn;
  } rule_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GEVAL,
    ST_GWAIT,
    ST_SMA,
    ST_SMUL,
    ST_SSTR,
    ST_RMUL1,
    ST_RMUL2,
    ST_RACC,
    ST_XMUL,
    ST_XACC,
    ST_CEN,
    ST_CWAIT,
    ST_DONE
  } state_t;

  localparam grade_t Q_ONE = 17'h10000;

  localparam int NTERMS    = 18;
  localparam int ANG_BASE  = 4;
  localparam int IN_LAST   = 8;
  localparam int LIN_BASE  = 9;
  localparam int LIN_LAST  = 12;
  localparam int TURN_BASE = 13;
  localparam int TURN_LAST = 17;
  localparam int NRULES    = 20;

  localparam int LIN_LO     = 0;
  localparam int LIN_RANGE  = 18022;
  localparam int TURN_LO    = -13107;
  localparam int TURN_RANGE = 26214;

  // distance 0..3, heading 4..8, linear 9..12, turn 13..17
  localparam trap_t TERMS [NTERMS] = '{
    '{18'sd0,      18'sd154,    18'sd307,    18'sd461},
    '{18'sd307,    18'sd461,    18'sd870,    18'sd1024},
    '{18'sd870,    18'sd1024,   18'sd4096,   18'sd4250},
    '{18'sd4096,   18'sd4250,   18'sd30720,  18'sd30874},
    '{-18'sd12861, -18'sd12452, -18'sd6144,  -18'sd5734},
    '{-18'sd6144,  -18'sd5734,  -18'sd819,   -18'sd410},
    '{-18'sd819,   -18'sd410,   18'sd410,    18'sd819},
    '{18'sd410,    18'sd819,    18'sd5734,   18'sd6144},
    '{18'sd5734,   18'sd6144,   18'sd12452,  18'sd12861},
    '{18'sd0,      18'sd1638,   18'sd4915,   18'sd6554},
    '{18'sd4915,   18'sd6554,   18'sd6554,   18'sd8192},
    '{18'sd6554,   18'sd8192,   18'sd8192,   18'sd9830},
    '{18'sd8192,   18'sd9830,   18'sd16384,  18'sd18022},
    '{-18'sd16384, -18'sd13107, -18'sd13107, -18'sd9830},
    '{-18'sd13107, -18'sd9830,  -18'sd9830,  -18'sd6554},
    '{-18'sd9830,  -18'sd6554,  18'sd6554,   18'sd9830},
    '{18'sd6554,   18'sd9830,   18'sd9830,   18'sd13107},
    '{18'sd9830,   18'sd13107,  18'sd13107,  18'sd16384}
  };

  localparam rule_t RULES [NRULES] = '{
    '{3'd0, 2'd3, 2'd0, 3'd0}, '{3'd0, 2'd2, 2'd0, 3'd0},
    '{3'd0, 2'd1, 2'd0, 3'd0}, '{3'd0, 2'd0, 2'd0, 3'd0},
    '{3'd1, 2'd3, 2'd0, 3'd1}, '{3'd1, 2'd2, 2'd0, 3'd1},
    '{3'd1, 2'd1, 2'd0, 3'd1}, '{3'd1, 2'd0, 2'd0, 3'd1},
    '{3'd3, 2'd3, 2'd0, 3'd3}, '{3'd3, 2'd2, 2'd0, 3'd3},
    '{3'd3, 2'd1, 2'd0, 3'd3}, '{3'd3, 2'd0, 2'd0, 3'd3},
    '{3'd4, 2'd3, 2'd0, 3'd4}, '{3'd4, 2'd2, 2'd0, 3'd4},
    '{3'd4, 2'd1, 2'd0, 3'd4}, '{3'd4, 2'd0, 2'd0, 3'd4},
    '{3'd2, 2'd3, 2'd3, 3'd2}, '{3'd2, 2'd2, 2'd2, 3'd2},
    '{3'd2, 2'd1, 2'd1, 3'd2}, '{3'd2, 2'd0, 2'd0, 3'd2}
  };

endpackage

>>> design/fsc_div.sv
// fsc_div: restoring divider, one quotient bit a cycle, 16-bit quotient.
// Needs hi < den; quotient is {hi,lo}/den. No package dependencies.
module fsc_div #(
  parameter int DEN_W = 28
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DEN_W-1:0] hi,
  input  logic [15:0]      lo,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [15:0]      q
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [15:0]      lo_r, lo_nxt;
  logic [15:0]      q_r, q_nxt;
  logic [DEN_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    trial    = {rem_r, lo_r[15]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = hi;
      den_nxt  = den;
      lo_nxt   = lo;
    end else if (busy_r) begin
      lo_nxt = {lo_r[14:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        q_nxt   = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = DEN_W'(trial);
        q_nxt   = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

>>> design/fuzzy_speed_controller.sv
// fuzzy_speed_controller: top level, sequencer around one 18x18 multiplier
// and the shared divider. Depends on fsc_pkg and fsc_div.
//
// Input words carry distance and heading errors; one result word follows
// each input word, with the two velocity centroids in tdata and the
// no-rule-fired flag in tuser.
// One word at a time: in_tready is high only while the block is idle.
// The sequencer walks the rules with the single multiplier (states
// RMUL1, RMUL2 and RACC for each rule) and uses the divider for each
// sloped membership grade and each centroid. Output grades depend only on
// the sample point, so the centroid walk is the same for every input word.
// The result sits in an output register; the next input word is taken
// while it waits, but the block holds its finished result until the
// receiver takes the previous one.
// Synchronous active-low reset clears the sequencer and out_tvalid.
module fuzzy_speed_controller #(
  parameter int SAMPLES = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // distance_error[15:0], angle_error[30:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // linear_speed[14:0], turn_rate[29:15]
  output logic        out_tuser   // no_rule_fired
);

  localparam int IW     = $clog2(SAMPLES);
  localparam int AREA_W = 17 + $clog2(SAMPLES);
  localparam int MOM_W  = AREA_W + 16;
  localparam int NUM_W  = MOM_W + 1;
  localparam int DEN_W  = AREA_W + 1;
  localparam int DS     = 2 * SAMPLES;
  localparam int RW     = $clog2(DS) + 1;

  localparam int LQ0 = fsc_pkg::LIN_RANGE / DS;
  localparam int LR0 = fsc_pkg::LIN_RANGE % DS;
  localparam int LQ2 = (2 * fsc_pkg::LIN_RANGE) / DS;
  localparam int LR2 = (2 * fsc_pkg::LIN_RANGE) % DS;
  localparam int TQ0 = fsc_pkg::TURN_RANGE / DS;
  localparam int TR0 = fsc_pkg::TURN_RANGE % DS;
  localparam int TQ2 = (2 * fsc_pkg::TURN_RANGE) / DS;
  localparam int TR2 = (2 * fsc_pkg::TURN_RANGE) % DS;

  localparam fsc_pkg::coord_t X0_LIN  = 18'(fsc_pkg::LIN_LO + LQ0);
  localparam fsc_pkg::coord_t X0_TURN = 18'(fsc_pkg::TURN_LO + TQ0);

  fsc_pkg::state_t state_r, state_nxt;

  logic [15:0]           dist_r, dist_nxt;
  logic signed [14:0]    ang_r, ang_nxt;
  logic [4:0]            t_r, t_nxt;
  logic [4:0]            rix_r, rix_nxt;
  logic [IW-1:0]         i_r, i_nxt;
  fsc_pkg::coord_t       x_r, x_nxt;
  logic [RW-1:0]         rem_r, rem_nxt;
  logic                  sel_r, sel_nxt;
  fsc_pkg::grade_t       s_r, s_nxt;
  fsc_pkg::grade_t       m1_r, m1_nxt;
  fsc_pkg::grade_t       opa_r, opa_nxt;
  logic signed [35:0]    p_r;
  logic [AREA_W-1:0]     area_r, area_nxt;
  logic signed [MOM_W-1:0] mom_r, mom_nxt;
  logic [14:0]           lin_r, lin_nxt;
  logic [14:0]           turn_r, turn_nxt;
  logic                  empty_r, empty_nxt;
  logic [31:0]           out_tdata_r, out_tdata_nxt;
  logic                  out_tuser_r, out_tuser_nxt;
  logic                  out_valid_r, out_valid_nxt;

  fsc_pkg::grade_t din_g [9];
  fsc_pkg::grade_t og [5];
  fsc_pkg::grade_t str [fsc_pkg::NRULES];

  fsc_pkg::trap_t     tr;
  fsc_pkg::coord_t    xg;
  fsc_pkg::coord_t    g_diff, g_den;
  logic               g_zero, g_rise, g_one;
  logic               gw_en;
  fsc_pkg::grade_t    gw_val;
  logic               str_we;
  logic [4:0]         grp_base, grp_last;
  logic [2:0]         og_wr, og_rd;
  fsc_pkg::rule_t     rl;
  logic signed [17:0] mul_a, mul_b;
  logic [MOM_W-1:0]   mag;
  logic [NUM_W-1:0]   num;
  logic               div_start, div_done;
  logic [DEN_W-1:0]   div_hi, div_den;
  logic [15:0]        div_lo, div_q;
  logic [15:0]        qs;
  logic               fin_en;
  logic [14:0]        fin_val;
  logic [RW-1:0]      rem_sum;

  fsc_div #(.DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .hi    (div_hi),
    .lo    (div_lo),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  always_comb begin
    tr = fsc_pkg::TERMS[t_r];
    if (t_r < 5'(fsc_pkg::ANG_BASE)) begin
      xg = fsc_pkg::coord_t'({2'b00, dist_r});
    end else if (t_r <= 5'(fsc_pkg::IN_LAST)) begin
      xg = fsc_pkg::coord_t'(ang_r);
    end else begin
      xg = x_r;
    end
    g_zero = (xg <= tr.a) || (xg >= tr.d);
    g_rise = xg < tr.b;
    g_one  = xg <= tr.c;
    g_diff = g_rise ? (xg - tr.a) : (tr.d - xg);
    g_den  = g_rise ? (tr.b - tr.a) : (tr.d - tr.c);

    grp_base = sel_r ? 5'(fsc_pkg::TURN_BASE) : 5'(fsc_pkg::LIN_BASE);
    grp_last = sel_r ? 5'(fsc_pkg::TURN_LAST) : 5'(fsc_pkg::LIN_LAST);
    og_wr    = 3'(t_r - grp_base);
    rl       = fsc_pkg::RULES[rix_r];
    og_rd    = sel_r ? rl.turn : {1'b0, rl.lin};

    mag = (mom_r < 0) ? $unsigned(-mom_r) : $unsigned(mom_r);
    num = {mag, 1'b0} + NUM_W'(area_r);

    rem_sum = rem_r + (sel_r ? RW'(TR2) : RW'(LR2));
    qs      = (mom_r < 0) ? (16'd0 - div_q) : div_q;
  end

  always_comb begin
    state_nxt     = state_r;
    dist_nxt      = dist_r;
    ang_nxt       = ang_r;
    t_nxt         = t_r;
    rix_nxt       = rix_r;
    i_nxt         = i_r;
    x_nxt         = x_r;
    rem_nxt       = rem_r;
    sel_nxt       = sel_r;
    s_nxt         = s_r;
    m1_nxt        = m1_r;
    opa_nxt       = opa_r;
    area_nxt      = area_r;
    mom_nxt       = mom_r;
    lin_nxt       = lin_r;
    turn_nxt      = turn_r;
    empty_nxt     = empty_r;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    out_valid_nxt = out_valid_r && !out_tready;
    gw_en         = 1'b0;
    gw_val        = '0;
    str_we        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_hi        = DEN_W'($unsigned(g_diff));
    div_lo        = '0;
    div_den       = DEN_W'($unsigned(g_den));
    fin_en        = 1'b0;
    fin_val       = '0;

    case (state_r)
      fsc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          dist_nxt  = in_tdata[15:0];
          ang_nxt   = in_tdata[30:16];
          empty_nxt = 1'b0;
          sel_nxt   = 1'b0;
          t_nxt     = '0;
          state_nxt = fsc_pkg::ST_GEVAL;
        end
      end
      fsc_pkg::ST_GEVAL: begin
        if (g_zero) begin
          gw_en = 1'b1;
        end else if (g_rise || !g_one) begin
          div_start = 1'b1;
          state_nxt = fsc_pkg::ST_GWAIT;
        end else begin
          gw_en  = 1'b1;
          gw_val = fsc_pkg::Q_ONE;
        end
      end
      fsc_pkg::ST_GWAIT: begin
        if (div_done) begin
          gw_en  = 1'b1;
          gw_val = {1'b0, div_q};
        end
      end
      fsc_pkg::ST_SMA: begin
        opa_nxt   = din_g[4'(fsc_pkg::ANG_BASE) + {1'b0, rl.ang}];
        state_nxt = fsc_pkg::ST_SMUL;
      end
      fsc_pkg::ST_SMUL: begin
        mul_a     = {1'b0, opa_r};
        mul_b     = {1'b0, din_g[{2'b00, rl.dst}]};
        state_nxt = fsc_pkg::ST_SSTR;
      end
      fsc_pkg::ST_SSTR: begin
        str_we = 1'b1;
        if (rix_r == 5'(fsc_pkg::NRULES - 1)) begin
          sel_nxt   = 1'b0;
          t_nxt     = 5'(fsc_pkg::LIN_BASE);
          i_nxt     = '0;
          x_nxt     = X0_LIN;
          rem_nxt   = RW'(LR0);
          area_nxt  = '0;
          mom_nxt   = '0;
          state_nxt = fsc_pkg::ST_GEVAL;
        end else begin
          rix_nxt   = rix_r + 5'd1;
          state_nxt = fsc_pkg::ST_SMA;
        end
      end
      fsc_pkg::ST_RMUL1: begin
        mul_a     = {1'b0, str[rix_r]};
        mul_b     = {1'b0, og[og_rd]};
        state_nxt = fsc_pkg::ST_RMUL2;
      end
      fsc_pkg::ST_RMUL2: begin
        mul_a     = {1'b0, s_r};
        mul_b     = {1'b0, p_r[32:16]};
        m1_nxt    = p_r[32:16];
        state_nxt = fsc_pkg::ST_RACC;
      end
      fsc_pkg::ST_RACC: begin
        s_nxt = 17'({1'b0, s_r} + {1'b0, m1_r} - {1'b0, p_r[32:16]});
        if (rix_r == 5'(fsc_pkg::NRULES - 1)) begin
          state_nxt = fsc_pkg::ST_XMUL;
        end else begin
          rix_nxt   = rix_r + 5'd1;
          state_nxt = fsc_pkg::ST_RMUL1;
        end
      end
      fsc_pkg::ST_XMUL: begin
        mul_a     = {1'b0, s_r};
        mul_b     = x_r;
        state_nxt = fsc_pkg::ST_XACC;
      end
      fsc_pkg::ST_XACC: begin
        area_nxt = area_r + AREA_W'(s_r);
        mom_nxt  = mom_r + MOM_W'(p_r);
        if (i_r == IW'(SAMPLES - 1)) begin
          state_nxt = fsc_pkg::ST_CEN;
        end else begin
          i_nxt = i_r + 1'b1;
          t_nxt = grp_base;
          if (rem_sum >= RW'(DS)) begin
            rem_nxt = rem_sum - RW'(DS);
            x_nxt   = x_r + (sel_r ? 18'(TQ2 + 1) : 18'(LQ2 + 1));
          end else begin
            rem_nxt = rem_sum;
            x_nxt   = x_r + (sel_r ? 18'(TQ2) : 18'(LQ2));
          end
          state_nxt = fsc_pkg::ST_GEVAL;
        end
      end
      fsc_pkg::ST_CEN: begin
        if (area_r == '0) begin
          empty_nxt = 1'b1;
          fin_en    = 1'b1;
        end else begin
          div_start = 1'b1;
          div_hi    = num[NUM_W-1:16];
          div_lo    = num[15:0];
          div_den   = {area_r, 1'b0};
          state_nxt = fsc_pkg::ST_CWAIT;
        end
      end
      fsc_pkg::ST_CWAIT: begin
        if (div_done) begin
          fin_en  = 1'b1;
          fin_val = qs[14:0];
        end
      end
      fsc_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_tdata_nxt = {2'b00, turn_r, lin_r};
          out_tuser_nxt = empty_r;
          out_valid_nxt = 1'b1;
          state_nxt     = fsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fsc_pkg::ST_IDLE;
      end
    endcase

    if (gw_en) begin
      if (t_r == 5'(fsc_pkg::IN_LAST)) begin
        rix_nxt   = '0;
        state_nxt = fsc_pkg::ST_SMA;
      end else if (t_r == grp_last) begin
        rix_nxt   = '0;
        s_nxt     = '0;
        state_nxt = fsc_pkg::ST_RMUL1;
      end else begin
        t_nxt     = t_r + 5'd1;
        state_nxt = fsc_pkg::ST_GEVAL;
      end
    end

    if (fin_en) begin
      if (!sel_r) begin
        lin_nxt   = fin_val;
        sel_nxt   = 1'b1;
        t_nxt     = 5'(fsc_pkg::TURN_BASE);
        i_nxt     = '0;
        x_nxt     = X0_TURN;
        rem_nxt   = RW'(TR0);
        area_nxt  = '0;
        mom_nxt   = '0;
        state_nxt = fsc_pkg::ST_GEVAL;
      end else begin
        turn_nxt  = fin_val;
        state_nxt = fsc_pkg::ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fsc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r      <= dist_nxt;
    ang_r       <= ang_nxt;
    t_r         <= t_nxt;
    rix_r       <= rix_nxt;
    i_r         <= i_nxt;
    x_r         <= x_nxt;
    rem_r       <= rem_nxt;
    sel_r       <= sel_nxt;
    s_r         <= s_nxt;
    m1_r        <= m1_nxt;
    opa_r       <= opa_nxt;
    p_r         <= mul_a * mul_b;
    area_r      <= area_nxt;
    mom_r       <= mom_nxt;
    lin_r       <= lin_nxt;
    turn_r      <= turn_nxt;
    empty_r     <= empty_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    if (gw_en && (t_r <= 5'(fsc_pkg::IN_LAST))) begin
      din_g[t_r[3:0]] <= gw_val;
    end
    if (gw_en && (t_r > 5'(fsc_pkg::IN_LAST))) begin
      og[og_wr] <= gw_val;
    end
    if (str_we) begin
      str[rix_r] <= p_r[32:16];
    end
  end

  assign in_tready  = (state_r == fsc_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
